// ===== design/klex_pkg.sv =====
package klex_pkg;

    localparam int KW_CHARS = 8;
    localparam int KW_BITS = KW_CHARS * 8;
    localparam int KW_COUNT = 12;
    localparam logic [7:0] LEN_LIMIT = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [11:0] COL_MAX = 12'hFFF;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_INT     = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_EQ      = 3'd4,
        MODE_GT      = 3'd5,
        MODE_LT      = 3'd6,
        MODE_BANG    = 3'd7
    } lex_mode_t;

    localparam logic [5:0] KIND_END    = 6'd0;
    localparam logic [5:0] KIND_ID     = 6'd1;
    localparam logic [5:0] KIND_INT    = 6'd2;
    localparam logic [5:0] KIND_KW0    = 6'd3;
    localparam logic [5:0] KIND_LPAREN = 6'd15;
    localparam logic [5:0] KIND_RPAREN = 6'd16;
    localparam logic [5:0] KIND_LBRACE = 6'd17;
    localparam logic [5:0] KIND_RBRACE = 6'd18;
    localparam logic [5:0] KIND_COMMA  = 6'd19;
    localparam logic [5:0] KIND_SEMI   = 6'd20;
    localparam logic [5:0] KIND_PLUS   = 6'd21;
    localparam logic [5:0] KIND_MINUS  = 6'd22;
    localparam logic [5:0] KIND_STAR   = 6'd23;
    localparam logic [5:0] KIND_SLASH  = 6'd24;
    localparam logic [5:0] KIND_ASSIGN = 6'd25;
    localparam logic [5:0] KIND_EQ     = 6'd26;
    localparam logic [5:0] KIND_GT     = 6'd27;
    localparam logic [5:0] KIND_GE     = 6'd28;
    localparam logic [5:0] KIND_LT     = 6'd29;
    localparam logic [5:0] KIND_LE     = 6'd30;
    localparam logic [5:0] KIND_NE     = 6'd31;
    localparam logic [5:0] KIND_ERR    = 6'd32;

    // Keyword text, first character in the lowest byte, zero padded.
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        KW_BITS'(64'h0000_0000_0034_3669),
        KW_BITS'(64'h0000_0000_0072_6176),
        KW_BITS'(64'h0000_0000_0000_6e66),
        KW_BITS'(64'h0000_0000_0000_6669),
        KW_BITS'(64'h0000_0000_6573_6c65),
        KW_BITS'(64'h6575_6e69_746e_6f63),
        KW_BITS'(64'h0000_0000_0072_6f66),
        KW_BITS'(64'h0000_006b_6165_7262),
        KW_BITS'(64'h0000_6e72_7574_6572),
        KW_BITS'(64'h0000_0000_0074_6f6e),
        KW_BITS'(64'h0000_0000_0064_6e61),
        KW_BITS'(64'h0000_0000_0000_726f)
    };

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd3, 8'd2, 8'd2, 8'd4, 8'd8, 8'd3, 8'd5, 8'd6, 8'd3, 8'd3, 8'd2
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [11:0] column;
        logic [7:0]  length;
        logic        last;
    } token_t;

endpackage

// ===== design/klex_scan.sv =====
module klex_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        chr,
    input  logic              end_of_input,
    output logic [1:0]        push_count,
    output klex_pkg::token_t  tok0,
    output klex_pkg::token_t  tok1
);

    klex_pkg::lex_mode_t mode_reg, mode_next;
    logic [klex_pkg::KW_BITS-1:0] kbuf_reg, kbuf_next;
    logic [7:0]  tlen_reg, tlen_next;
    logic [15:0] line_reg, line_next;
    logic [11:0] col_reg, col_next;
    logic [15:0] sline_reg, sline_next;
    logic [11:0] scol_reg, scol_next;
    logic        done_reg, done_next;

    logic [11:0] col_now;
    logic chr_num, is_alpha, chr_blank, is_hash, is_nl, is_eqc, is_opstart;
    logic op_mode, cont, pair, do_start, flush_on, start_emits, live;
    logic [5:0] start_kind, flush_kind, pair_kind, ident_kind;
    klex_pkg::token_t flush_tok, start_tok, end_tok, pair_tok;

    assign col_now  = (col_reg < klex_pkg::COL_MAX) ? col_reg + 12'd1 : klex_pkg::COL_MAX;
    assign chr_num  = (chr >= 8'h30) && (chr <= 8'h39);
    assign is_alpha = ((chr >= 8'h61) && (chr <= 8'h7a)) || ((chr >= 8'h41) && (chr <= 8'h5a));
    assign chr_blank = (chr == 8'h20) || ((chr >= 8'd9) && (chr <= 8'd13));
    assign is_hash  = (chr == 8'h23);
    assign is_nl    = (chr == 8'h0a);
    assign is_eqc   = (chr == 8'h3d);
    assign is_opstart = is_eqc || (chr == 8'h3e) || (chr == 8'h3c) || (chr == 8'h21);

    assign live    = take && !done_reg;
    assign op_mode = (mode_reg == klex_pkg::MODE_EQ) || (mode_reg == klex_pkg::MODE_GT)
                  || (mode_reg == klex_pkg::MODE_LT) || (mode_reg == klex_pkg::MODE_BANG);
    assign cont    = ((mode_reg == klex_pkg::MODE_INT) && chr_num)
                  || ((mode_reg == klex_pkg::MODE_IDENT) && (chr_num || is_alpha));
    assign pair    = op_mode && is_eqc;
    assign do_start = (mode_reg != klex_pkg::MODE_COMMENT) && !cont && !pair;
    assign flush_on = (mode_reg != klex_pkg::MODE_IDLE) && (mode_reg != klex_pkg::MODE_COMMENT);
    assign start_emits = do_start && !is_hash && !chr_blank && !chr_num && !is_alpha
                      && !is_opstart;

    always_comb begin
        ident_kind = klex_pkg::KIND_ID;
        for (int i = klex_pkg::KW_COUNT - 1; i >= 0; i--) begin
            if ((tlen_reg == klex_pkg::KW_LEN[i]) && (kbuf_reg == klex_pkg::KW_TEXT[i])) begin
                ident_kind = 6'(klex_pkg::KIND_KW0 + 6'(i));
            end
        end
    end

    always_comb begin
        case (chr)
            8'h28:   start_kind = klex_pkg::KIND_LPAREN;
            8'h29:   start_kind = klex_pkg::KIND_RPAREN;
            8'h7b:   start_kind = klex_pkg::KIND_LBRACE;
            8'h7d:   start_kind = klex_pkg::KIND_RBRACE;
            8'h2c:   start_kind = klex_pkg::KIND_COMMA;
            8'h3b:   start_kind = klex_pkg::KIND_SEMI;
            8'h2b:   start_kind = klex_pkg::KIND_PLUS;
            8'h2d:   start_kind = klex_pkg::KIND_MINUS;
            8'h2a:   start_kind = klex_pkg::KIND_STAR;
            8'h2f:   start_kind = klex_pkg::KIND_SLASH;
            default: start_kind = klex_pkg::KIND_ERR;
        endcase
    end

    always_comb begin
        case (mode_reg)
            klex_pkg::MODE_INT:   flush_kind = klex_pkg::KIND_INT;
            klex_pkg::MODE_IDENT: flush_kind = ident_kind;
            klex_pkg::MODE_EQ:    flush_kind = klex_pkg::KIND_ASSIGN;
            klex_pkg::MODE_GT:    flush_kind = klex_pkg::KIND_GT;
            klex_pkg::MODE_LT:    flush_kind = klex_pkg::KIND_LT;
            default:              flush_kind = klex_pkg::KIND_ERR;
        endcase
        case (mode_reg)
            klex_pkg::MODE_EQ: pair_kind = klex_pkg::KIND_EQ;
            klex_pkg::MODE_GT: pair_kind = klex_pkg::KIND_GE;
            klex_pkg::MODE_LT: pair_kind = klex_pkg::KIND_LE;
            default:           pair_kind = klex_pkg::KIND_NE;
        endcase
    end

    // Next state.
    always_comb begin
        mode_next  = mode_reg;
        kbuf_next  = kbuf_reg;
        tlen_next  = tlen_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        done_next  = done_reg;
        if (live) begin
            if (end_of_input) begin
                mode_next = klex_pkg::MODE_IDLE;
                done_next = 1'b1;
            end else begin
                if (do_start) begin
                    sline_next = line_reg;
                    scol_next  = col_now;
                    tlen_next  = 8'd0;
                    mode_next  = klex_pkg::MODE_IDLE;
                    if (is_hash) begin
                        mode_next = klex_pkg::MODE_COMMENT;
                    end else if (chr_num) begin
                        mode_next = klex_pkg::MODE_INT;
                        kbuf_next[7:0] = chr;
                        tlen_next = 8'd1;
                    end else if (is_alpha) begin
                        mode_next = klex_pkg::MODE_IDENT;
                        kbuf_next = {{(klex_pkg::KW_BITS-8){1'b0}}, chr};
                        tlen_next = 8'd1;
                    end else if (is_eqc) begin
                        mode_next = klex_pkg::MODE_EQ;
                    end else if (chr == 8'h3e) begin
                        mode_next = klex_pkg::MODE_GT;
                    end else if (chr == 8'h3c) begin
                        mode_next = klex_pkg::MODE_LT;
                    end else if (chr == 8'h21) begin
                        mode_next = klex_pkg::MODE_BANG;
                    end
                end else if (cont) begin
                    for (int b = 0; b < klex_pkg::KW_CHARS; b++) begin
                        if (tlen_reg == 8'(b)) begin
                            kbuf_next[b*8 +: 8] = chr;
                        end
                    end
                    if (tlen_reg < klex_pkg::LEN_LIMIT) begin
                        tlen_next = tlen_reg + 8'd1;
                    end
                end else if (pair || is_nl) begin
                    mode_next = klex_pkg::MODE_IDLE;
                end
                if (is_nl) begin
                    if (line_reg < klex_pkg::LINE_MAX) begin
                        line_next = line_reg + 16'd1;
                    end
                    col_next = 12'd0;
                end else begin
                    col_next = col_now;
                end
            end
        end
    end

    // Result tokens.
    always_comb begin
        flush_tok = '{kind: flush_kind, line: sline_reg, column: scol_reg,
                      length: ((mode_reg == klex_pkg::MODE_INT)
                               || (mode_reg == klex_pkg::MODE_IDENT)) ? tlen_reg : 8'd1,
                      last: 1'b0};
        start_tok = '{kind: start_kind, line: line_reg, column: col_now, length: 8'd1,
                      last: 1'b1};
        end_tok   = '{kind: klex_pkg::KIND_END, line: line_reg, column: col_now,
                      length: 8'd0, last: 1'b1};
        pair_tok  = '{kind: pair_kind, line: sline_reg, column: scol_reg, length: 8'd2,
                      last: 1'b1};
        tok1 = start_tok;
        if (end_of_input) begin
            tok0 = flush_on ? flush_tok : end_tok;
            tok1 = end_tok;
            push_count = flush_on ? 2'd2 : 2'd1;
        end else if (pair) begin
            tok0 = pair_tok;
            push_count = 2'd1;
        end else begin
            tok0 = flush_on && do_start ? flush_tok : start_tok;
            push_count = 2'(flush_on && do_start) + 2'(start_emits);
        end
        tok0.last = (push_count == 2'd1);
        if (!live) begin
            push_count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= klex_pkg::MODE_IDLE;
            kbuf_reg  <= '0;
            tlen_reg  <= 8'd0;
            line_reg  <= 16'd1;
            col_reg   <= 12'd0;
            sline_reg <= 16'd1;
            scol_reg  <= 12'd0;
            done_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            kbuf_reg  <= kbuf_next;
            tlen_reg  <= tlen_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== design/klex_queue.sv =====
module klex_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  klex_pkg::token_t  tok0,
    input  klex_pkg::token_t  tok1,
    input  logic              pop,
    output logic              room,
    output logic              head_valid,
    output klex_pkg::token_t  head
);

    klex_pkg::token_t mem [klex_pkg::QUEUE_DEPTH];
    logic [klex_pkg::QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [klex_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign room       = (cnt_reg <= klex_pkg::QCNT_W'(klex_pkg::QUEUE_DEPTH - 2));
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = wr_reg + klex_pkg::QPTR_W'(push_count);
        rd_next  = rd_reg + klex_pkg::QPTR_W'(do_pop);
        cnt_next = cnt_reg + klex_pkg::QCNT_W'(push_count) - klex_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_reg] <= tok0;
        end
        if (push_count == 2'd2) begin
            mem[wr_reg + klex_pkg::QPTR_W'(1)] <= tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/keyword_lexer_core.sv =====
// Channel   Direction  Ports
// request   in         s_valid, s_ready, s_chr, s_end_of_input
// token     out        m_valid, m_ready, m_kind, m_line, m_column, m_length, m_last_of_run
//
// One request is taken per cycle while s_ready is high; its tokens (zero to two) are queued.
// A four-entry token queue fed by the lexer step sets the rate: s_ready is high while
// at least two entries are free, so a stalled token side stops requests once three tokens wait.
// Reset is synchronous and active low; it clears the lexer position and the queue.
// After the end token, requests are still taken but cause no tokens until reset.
module keyword_lexer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_chr,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_kind,
    output logic [15:0] m_line,
    output logic [11:0] m_column,
    output logic [7:0]  m_length,
    output logic        m_last_of_run
);

    logic [1:0] push_count;
    klex_pkg::token_t tok0, tok1, head;

    klex_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (s_valid && s_ready),
        .chr          (s_chr),
        .end_of_input (s_end_of_input),
        .push_count   (push_count),
        .tok0         (tok0),
        .tok1         (tok1)
    );

    klex_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .tok0       (tok0),
        .tok1       (tok1),
        .pop        (m_ready),
        .room       (s_ready),
        .head_valid (m_valid),
        .head       (head)
    );

    assign m_kind        = head.kind;
    assign m_line        = head.line;
    assign m_column      = head.column;
    assign m_length      = head.length;
    assign m_last_of_run = head.last;

endmodule

// ===== design/klex_checker.sv =====
module klex_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_chr,
    input logic        s_end_of_input,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_kind,
    input logic [15:0] m_line,
    input logic [11:0] m_column,
    input logic [7:0]  m_length,
    input logic        m_last_of_run
);

    // A stalled token keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_line)
                                && $stable(m_column) && $stable(m_length)
                                && $stable(m_last_of_run))
        else $error("token changed while stalled");

    // The end token closes its request and carries no characters.
    a_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == klex_pkg::KIND_END) |-> m_last_of_run && (m_length == 8'd0))
        else $error("malformed end token");

    // Nothing follows the end token.
    a_end_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_kind == klex_pkg::KIND_END) |=> !m_valid)
        else $error("token after end token");

    // Positions start at one.
    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line != 16'd0) && (m_column != 12'd0))
        else $error("token position zero");

    // Reset empties the token queue.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("tokens present after reset");

endmodule

bind keyword_lexer_core klex_checker u_klex_checker (.*);

// ===== tb/token_checker.sv =====
module token_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_chr,
    input  logic        s_end_of_input,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_kind,
    input  logic [15:0] m_line,
    input  logic [11:0] m_column,
    input  logic [7:0]  m_length,
    input  logic        m_last_of_run,
    output int          mismatch_count,
    output int          pending_tokens
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAD_CHARS = 8;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Keyword text, last character in the lowest byte, zero padded on the left.
    localparam logic [63:0] KW_WORDS [12] = '{
        "i64", "var", "fn", "if", "else", "continue",
        "for", "break", "return", "not", "and", "or"
    };

    klex_pkg::lex_mode_t mode;
    logic [63:0] word_head;
    logic [7:0]  tok_len;
    logic [15:0] line_cnt;
    logic [15:0] tok_line;
    logic [11:0] col_cnt;
    logic [11:0] tok_col;
    logic        lexer_done;
    klex_pkg::token_t expected_tokens [$];

    function automatic bit is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void push_token(logic [5:0] kind, logic [15:0] ln, logic [11:0] col,
                                       logic [7:0] len);
        klex_pkg::token_t t;
        t.kind = kind;
        t.line = ln;
        t.column = col;
        t.length = len;
        t.last = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void grow_token(logic [7:0] c);
        if (tok_len < HEAD_CHARS) begin
            word_head = {word_head[55:0], c};
        end
        if (tok_len != klex_pkg::LEN_LIMIT) begin
            tok_len = tok_len + 8'd1;
        end
    endfunction

    function automatic void flush_pending();
        logic [5:0] k;
        case (mode)
            klex_pkg::MODE_INT: begin
                push_token(klex_pkg::KIND_INT, tok_line, tok_col, tok_len);
            end
            klex_pkg::MODE_IDENT: begin
                k = klex_pkg::KIND_ID;
                if (tok_len <= HEAD_CHARS) begin
                    for (int i = 0; i < 12; i++) begin
                        if (word_head == KW_WORDS[i]) begin
                            k = klex_pkg::KIND_KW0 + 6'(i);
                        end
                    end
                end
                push_token(k, tok_line, tok_col, tok_len);
            end
            klex_pkg::MODE_EQ:   push_token(klex_pkg::KIND_ASSIGN, tok_line, tok_col, 8'd1);
            klex_pkg::MODE_GT:   push_token(klex_pkg::KIND_GT, tok_line, tok_col, 8'd1);
            klex_pkg::MODE_LT:   push_token(klex_pkg::KIND_LT, tok_line, tok_col, 8'd1);
            klex_pkg::MODE_BANG: push_token(klex_pkg::KIND_ERR, tok_line, tok_col, 8'd1);
            default: ;
        endcase
        mode = klex_pkg::MODE_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [15:0] ln, logic [11:0] col);
        logic [5:0] k;
        tok_line = ln;
        tok_col = col;
        tok_len = 8'd0;
        if (c == "#") begin
            mode = klex_pkg::MODE_COMMENT;
        end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            mode = klex_pkg::MODE_IDLE;
        end else if (is_numeral(c)) begin
            mode = klex_pkg::MODE_INT;
            grow_token(c);
        end else if (is_alpha(c)) begin
            word_head = '0;
            mode = klex_pkg::MODE_IDENT;
            grow_token(c);
        end else begin
            case (c)
                "(":     k = klex_pkg::KIND_LPAREN;
                ")":     k = klex_pkg::KIND_RPAREN;
                "{":     k = klex_pkg::KIND_LBRACE;
                "}":     k = klex_pkg::KIND_RBRACE;
                ",":     k = klex_pkg::KIND_COMMA;
                ";":     k = klex_pkg::KIND_SEMI;
                "+":     k = klex_pkg::KIND_PLUS;
                "-":     k = klex_pkg::KIND_MINUS;
                "*":     k = klex_pkg::KIND_STAR;
                "/":     k = klex_pkg::KIND_SLASH;
                default: k = klex_pkg::KIND_ERR;
            endcase
            case (c)
                "=":     mode = klex_pkg::MODE_EQ;
                ">":     mode = klex_pkg::MODE_GT;
                "<":     mode = klex_pkg::MODE_LT;
                "!":     mode = klex_pkg::MODE_BANG;
                default: push_token(k, ln, col, 8'd1);
            endcase
        end
    endfunction

    function automatic void lex_step(logic [7:0] c, logic eoi);
        logic [15:0] ln;
        logic [11:0] col;
        logic [5:0]  k;
        int          before_cnt;
        if (lexer_done) begin
            return;
        end
        before_cnt = expected_tokens.size();
        ln = line_cnt;
        col = (col_cnt < klex_pkg::COL_MAX) ? col_cnt + 12'd1 : klex_pkg::COL_MAX;
        if (eoi) begin
            flush_pending();
            push_token(klex_pkg::KIND_END, ln, col, 8'd0);
            lexer_done = 1'b1;
        end else begin
            case (mode)
                klex_pkg::MODE_IDLE: start_token(c, ln, col);
                klex_pkg::MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        mode = klex_pkg::MODE_IDLE;
                    end
                end
                klex_pkg::MODE_INT: begin
                    if (is_numeral(c)) begin
                        grow_token(c);
                    end else begin
                        flush_pending();
                        start_token(c, ln, col);
                    end
                end
                klex_pkg::MODE_IDENT: begin
                    if (is_numeral(c) || is_alpha(c)) begin
                        grow_token(c);
                    end else begin
                        flush_pending();
                        start_token(c, ln, col);
                    end
                end
                default: begin
                    if (c == "=") begin
                        case (mode)
                            klex_pkg::MODE_EQ: k = klex_pkg::KIND_EQ;
                            klex_pkg::MODE_GT: k = klex_pkg::KIND_GE;
                            klex_pkg::MODE_LT: k = klex_pkg::KIND_LE;
                            default:           k = klex_pkg::KIND_NE;
                        endcase
                        push_token(k, tok_line, tok_col, 8'd2);
                        mode = klex_pkg::MODE_IDLE;
                    end else begin
                        flush_pending();
                        start_token(c, ln, col);
                    end
                end
            endcase
            if (c == CH_LF) begin
                if (line_cnt != klex_pkg::LINE_MAX) begin
                    line_cnt = line_cnt + 16'd1;
                end
                col_cnt = 12'd0;
            end else begin
                col_cnt = col;
            end
        end
        if (expected_tokens.size() > before_cnt) begin
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        klex_pkg::token_t want;
        if (!aresetn) begin
            mode = klex_pkg::MODE_IDLE;
            word_head = '0;
            tok_len = 8'd0;
            line_cnt = 16'd1;
            col_cnt = 12'd0;
            tok_line = 16'd1;
            tok_col = 12'd0;
            lexer_done = 1'b0;
            expected_tokens.delete();
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected token kind %0d line %0d col %0d len %0d last %0b",
                                 $realtime, m_kind, m_line, m_column, m_length, m_last_of_run);
                    end
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_kind !== want.kind || m_line !== want.line ||
                        m_column !== want.column || m_length !== want.length ||
                        m_last_of_run !== want.last) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected kind %0d line %0d col %0d len %0d last %0b",
                                     $realtime, want.kind, want.line, want.column,
                                     want.length, want.last);
                            $display("%0t: got      kind %0d line %0d col %0d len %0d last %0b",
                                     $realtime, m_kind, m_line, m_column, m_length,
                                     m_last_of_run);
                        end
                    end
                end
            end
            if (s_valid && s_ready === 1'b1) begin
                lex_step(s_chr, s_end_of_input);
            end
        end
        pending_tokens = expected_tokens.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_chr;
    logic        s_end_of_input;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_kind;
    logic [15:0] m_line;
    logic [11:0] m_column;
    logic [7:0]  m_length;
    logic        m_last_of_run;

    int mismatch_count;
    int pending_tokens;
    int items_sent = 0;
    bit sender_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    bit hold_tokens = 1'b0;

    keyword_lexer_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_chr          (s_chr),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_line         (m_line),
        .m_column       (m_column),
        .m_length       (m_length),
        .m_last_of_run  (m_last_of_run)
    );

    token_checker tokens_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_chr          (s_chr),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_line         (m_line),
        .m_column       (m_column),
        .m_length       (m_length),
        .m_last_of_run  (m_last_of_run),
        .mismatch_count (mismatch_count),
        .pending_tokens (pending_tokens)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 52) ? rand_letter() : 8'("0" + r - 52);
    endfunction

    function automatic string keyword_text(int idx);
        case (idx)
            0:       return "i64";
            1:       return "var";
            2:       return "fn";
            3:       return "if";
            4:       return "else";
            5:       return "continue";
            6:       return "for";
            7:       return "break";
            8:       return "return";
            9:       return "not";
            10:      return "and";
            default: return "or";
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(logic [7:0] c, logic eoi);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_chr = c;
        s_end_of_input = eoi;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(logic [7:0] c);
        send_request(c, 1'b0);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_fragment();
        int         sel;
        int         len;
        logic [7:0] c;
        string      punct;
        punct = "(){},;+-*/=<>!";
        sel = $urandom_range(0, 19);
        if (sel < 4) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_byte(rand_letter());
            repeat (len - 1) send_byte(rand_alnum());
        end else if (sel < 7) begin
            send_text(keyword_text($urandom_range(0, 11)));
            if ($urandom_range(0, 3) == 0) begin
                send_byte(rand_alnum());
            end
        end else if (sel < 9) begin
            repeat ($urandom_range(1, 6)) send_byte(8'("0" + $urandom_range(0, 9)));
        end else if (sel < 12) begin
            send_byte(punct[$urandom_range(0, punct.len() - 1)]);
            if ($urandom_range(0, 1) == 0) begin
                send_byte("=");
            end
        end else if (sel < 15) begin
            len = $urandom_range(0, 5);
            send_byte((len == 0) ? 8'h20 : 8'(8 + len));
        end else if (sel < 16) begin
            send_byte("#");
            repeat ($urandom_range(0, 12)) begin
                c = 8'($urandom_range(0, 255));
                send_byte((c == 8'h0A) ? 8'h20 : c);
            end
            send_byte(8'h0A);
        end else if (sel < 18) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(($urandom_range(0, 1) == 0) ? "_" : 8'($urandom_range(128, 255)));
        end
    endtask

    initial begin
        int r;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_tokens) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_tokens = 1'b0;
            end else if (sink_quiet) begin
                m_ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready = 1'b1;
                end else if (r < 96) begin
                    m_ready = 1'b0;
                    repeat ($urandom_range(0, 3)) @(negedge aclk);
                end else begin
                    m_ready = 1'b0;
                    repeat ($urandom_range(5, 40)) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        int frag;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_chr = 8'h00;
        s_end_of_input = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_text("!a_");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("<=!=>x=5!");
        send_byte(8'h0B);
        send_byte(8'h0C);
        send_byte(8'h0D);
        send_byte(8'h09);
        send_byte("#");
        send_byte(8'h00);
        send_byte(8'h0A);
        send_text("continue9 or");

        frag = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (frag % 40 == 0) begin
                sender_quiet = ($urandom_range(0, 4) == 0);
                sink_quiet = ($urandom_range(0, 4) == 0);
            end
            if (frag == 80) begin
                sink_quiet = 1'b0;
                hold_tokens = 1'b1;
            end
            if (frag == 200) begin
                s_valid = 1'b0;
                while (pending_tokens != 0) @(negedge aclk);
            end
            send_fragment();
            frag++;
        end

        // Saturate the token length with a long number and a long identifier.
        sender_quiet = 1'b1;
        sink_quiet = 1'b0;
        send_byte(8'h0A);
        repeat (300) send_byte(8'("0" + $urandom_range(0, 9)));
        send_text(" continue");
        repeat (280) send_byte(rand_alnum());
        send_byte(" ");
        send_text("(;>=");
        send_byte(8'h0A);
        send_text("a+1 b");
        sender_quiet = 1'b0;
        send_request(8'($urandom_range(0, 255)), 1'b1);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        send_request(8'($urandom_range(0, 255)), 1'b1);
        send_text("z;");

        s_valid = 1'b0;
        while (pending_tokens != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && pending_tokens == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/klex_pkg.sv
design/klex_scan.sv
design/klex_queue.sv
design/keyword_lexer_core.sv
design/klex_checker.sv
tb/token_checker.sv
tb/tb_top.sv
